// ===== design/hkr_pkg.sv =====
// ----------------------------------------------------------------------------
// hkr_pkg
// Shared widths, operation codes and the result word for the heap key block.
// ----------------------------------------------------------------------------
package hkr_pkg;

  localparam int KEY_W  = 32;
  localparam int IDX_W  = 10;
  localparam int SIZE_W = 11;
  localparam int MODE_W = 2;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 48;

  localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

  typedef struct packed {
    logic signed [KEY_W-1:0] read_value;
    logic        [IDX_W-1:0] final_position;
    logic                    error;
  } result_t;

endpackage

// ===== design/hkr_store.sv =====
// ----------------------------------------------------------------------------
// hkr_store
// Key memory: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module hkr_store #(
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [AW-1:0]                   waddr,
  input  logic signed [hkr_pkg::KEY_W-1:0] wdata,
  input  logic [AW-1:0]                   ra_addr,
  input  logic [AW-1:0]                   rb_addr,
  output logic signed [hkr_pkg::KEY_W-1:0] ra_data,
  output logic signed [hkr_pkg::KEY_W-1:0] rb_data
);

  logic signed [hkr_pkg::KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

// ===== design/hkr_ctrl.sv =====
// ----------------------------------------------------------------------------
// hkr_ctrl
// Sequencer: decodes each word, walks the heap through the key memory and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module hkr_ctrl #(
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int NW = $clog2(DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [NW-1:0]                    size_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [hkr_pkg::MODE_W-1:0]       in_mode,
  input  logic [hkr_pkg::IDX_W-1:0]        in_index,
  input  logic signed [hkr_pkg::KEY_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output hkr_pkg::result_t                 out_res,
  output logic                             mem_we,
  output logic [AW-1:0]                    mem_waddr,
  output logic signed [hkr_pkg::KEY_W-1:0] mem_wdata,
  output logic [AW-1:0]                    mem_ra_addr,
  output logic [AW-1:0]                    mem_rb_addr,
  input  logic signed [hkr_pkg::KEY_W-1:0] mem_ra_data,
  input  logic signed [hkr_pkg::KEY_W-1:0] mem_rb_data
);

  localparam int XW = (AW + 2 > hkr_pkg::IDX_W + 1) ? AW + 2 : hkr_pkg::IDX_W + 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DN_RD  = 3'd1;
  localparam logic [2:0] ST_DN_CMP = 3'd2;
  localparam logic [2:0] ST_UP_RD  = 3'd3;
  localparam logic [2:0] ST_UP_CMP = 3'd4;
  localparam logic [2:0] ST_RD_WT  = 3'd5;
  localparam logic [2:0] ST_FINAL  = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  logic [2:0]                       state, state_next;
  logic [AW-1:0]                    pos, pos_next;
  logic signed [hkr_pkg::KEY_W-1:0] key, key_next;
  logic                             moved, moved_next;
  hkr_pkg::result_t                 res, res_next;

  logic [XW-1:0]                    n_x, idx_x, pos_x, left_x, right_x;
  logic                             left_ok, right_ok, idx_err, accept, out_load;
  logic [AW-1:0]                    parent;
  logic                             pick_right, go_down, go_up;
  logic signed [hkr_pkg::KEY_W-1:0] pick_val;
  logic [AW-1:0]                    pick_pos;

  assign n_x      = {{(XW-NW){1'b0}}, size_n};
  assign idx_x    = {{(XW-hkr_pkg::IDX_W){1'b0}}, in_index};
  assign pos_x    = {{(XW-AW){1'b0}}, pos};
  assign left_x   = {pos_x[XW-2:0], 1'b1};
  assign right_x  = left_x + XW'(1);
  assign left_ok  = left_x < n_x;
  assign right_ok = right_x < n_x;
  assign idx_err  = idx_x >= n_x;
  assign parent   = AW'((pos - AW'(1)) >> 1);

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state == ST_FINISH) && (!out_valid || out_ready);

  // Ties between the children go left; a key equal to the smaller child stays.
  assign pick_right = right_ok && (mem_rb_data < mem_ra_data);
  assign pick_val   = pick_right ? mem_rb_data : mem_ra_data;
  assign pick_pos   = pick_right ? right_x[AW-1:0] : left_x[AW-1:0];
  assign go_down    = key > pick_val;
  assign go_up      = key < mem_ra_data;

  always_comb begin
    mem_ra_addr = idx_x[AW-1:0];
    mem_rb_addr = right_x[AW-1:0];
    unique case (state)
      ST_DN_RD: mem_ra_addr = left_x[AW-1:0];
      ST_UP_RD: mem_ra_addr = parent;
      default:  mem_ra_addr = idx_x[AW-1:0];
    endcase
  end

  always_comb begin
    state_next = state;
    pos_next   = pos;
    key_next   = key;
    moved_next = moved;
    res_next   = res;
    mem_we     = 1'b0;
    mem_waddr  = pos;
    mem_wdata  = key;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          pos_next   = idx_x[AW-1:0];
          key_next   = in_value;
          moved_next = 1'b0;
          res_next   = '0;
          priority if (in_mode == hkr_pkg::MODE_NONE) begin
            state_next = ST_FINISH;
          end else if (idx_err) begin
            res_next.error = 1'b1;
            state_next     = ST_FINISH;
          end else if (in_mode == hkr_pkg::MODE_WRITE) begin
            mem_we                  = 1'b1;
            mem_waddr               = idx_x[AW-1:0];
            mem_wdata               = in_value;
            res_next.final_position = in_index;
            state_next              = ST_FINISH;
          end else if (in_mode == hkr_pkg::MODE_UPDATE) begin
            state_next = ST_DN_RD;
          end else begin
            state_next = ST_RD_WT;
          end
        end
      end
      ST_DN_RD: begin
        priority if (left_ok) state_next = ST_DN_CMP;
        else if (moved)       state_next = ST_FINAL;
        else                  state_next = ST_UP_RD;
      end
      ST_DN_CMP: begin
        if (go_down) begin
          // Pull the smaller child up into the hole and follow it.
          mem_we     = 1'b1;
          mem_wdata  = pick_val;
          pos_next   = pick_pos;
          moved_next = 1'b1;
          state_next = ST_DN_RD;
        end else begin
          state_next = moved ? ST_FINAL : ST_UP_RD;
        end
      end
      ST_UP_RD: begin
        state_next = (pos == '0) ? ST_FINAL : ST_UP_CMP;
      end
      ST_UP_CMP: begin
        if (go_up) begin
          mem_we     = 1'b1;
          mem_wdata  = mem_ra_data;
          pos_next   = parent;
          state_next = ST_UP_RD;
        end else begin
          state_next = ST_FINAL;
        end
      end
      ST_RD_WT: begin
        res_next.read_value     = mem_ra_data;
        res_next.final_position = pos_x[hkr_pkg::IDX_W-1:0];
        state_next              = ST_FINISH;
      end
      ST_FINAL: begin
        // Drop the new key into the hole where the walk stopped.
        mem_we                  = 1'b1;
        res_next.final_position = pos_x[hkr_pkg::IDX_W-1:0];
        state_next              = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos   <= pos_next;
    key   <= key_next;
    moved <= moved_next;
    res   <= res_next;
    if (out_load) begin
      out_res <= res;
    end
  end

  a_pos_in_heap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DN_RD || state == ST_UP_RD || state == ST_FINAL) |-> pos_x < n_x)
    else $error("walk position outside the heap");

  a_no_up_after_down: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UP_CMP) |-> !moved)
    else $error("sift up after a sift down");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.error) |-> (out_res.read_value == '0 && out_res.final_position == '0))
    else $error("error word carries data");

  a_write_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == ST_IDLE) |-> (accept && in_mode == hkr_pkg::MODE_WRITE && !idx_err))
    else $error("unexpected memory write while idle");

endmodule

// ===== design/heap_key_replace.sv =====
// ----------------------------------------------------------------------------
// heap_key_replace
// Binary min-heap of signed keys with raw write, key update and read.
// ----------------------------------------------------------------------------
// One word is taken at a time. An update sifts down, or up when it did not
// move down, one tree level per read and compare: both children, or the
// parent, are read from the dual-read key memory in one state and compared
// in the next. heap_size above HEAP_DEPTH acts as HEAP_DEPTH; change it only
// while no word is in flight. Memory contents are undefined until written.
module heap_key_replace #(
  parameter int HEAP_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hkr_pkg::SIZE_W-1:0]      cfg_data,      // heap_size
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [hkr_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // index[9:0], value[41:10]
  input  logic [hkr_pkg::MODE_W-1:0]      s_axis_tuser,  // mode
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [hkr_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // read_value[31:0], final_position[41:32]
  output logic                            m_axis_tuser   // error
);

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int NW = $clog2(HEAP_DEPTH + 1);
  localparam int SW = (NW > hkr_pkg::SIZE_W) ? NW : hkr_pkg::SIZE_W;
  localparam int PAD_W = hkr_pkg::M_TDATA_W - hkr_pkg::KEY_W - hkr_pkg::IDX_W;

  logic [hkr_pkg::SIZE_W-1:0]       heap_size;
  logic [SW-1:0]                    size_x, n_x;
  logic [NW-1:0]                    size_n;
  hkr_pkg::result_t                 out_res;
  logic                             mem_we;
  logic [AW-1:0]                    mem_waddr, mem_ra_addr, mem_rb_addr;
  logic signed [hkr_pkg::KEY_W-1:0] mem_wdata, mem_ra_data, mem_rb_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_size <= '0;
    end else if (cfg_valid && cfg_ready) begin
      heap_size <= cfg_data;
    end
  end

  // Clamp the size to the memory depth.
  assign size_x = SW'(heap_size);
  assign n_x    = (size_x > SW'(HEAP_DEPTH)) ? SW'(HEAP_DEPTH) : size_x;
  assign size_n = n_x[NW-1:0];

  hkr_ctrl #(
    .DEPTH(HEAP_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .size_n     (size_n),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_mode    (s_axis_tuser),
    .in_index   (s_axis_tdata[hkr_pkg::IDX_W-1:0]),
    .in_value   (s_axis_tdata[hkr_pkg::IDX_W +: hkr_pkg::KEY_W]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_res    (out_res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_ra_addr(mem_ra_addr),
    .mem_rb_addr(mem_rb_addr),
    .mem_ra_data(mem_ra_data),
    .mem_rb_data(mem_rb_data)
  );

  hkr_store #(
    .DEPTH(HEAP_DEPTH)
  ) u_store (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .ra_addr(mem_ra_addr),
    .rb_addr(mem_rb_addr),
    .ra_data(mem_ra_data),
    .rb_data(mem_rb_data)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, out_res.final_position, out_res.read_value};
  assign m_axis_tuser = out_res.error;

endmodule
